>>> src/wbps_pkg.sv
package wbps_pkg;

    // Longest pattern the block supports
    localparam int MAX_PATTERN_BYTES = 32;
    localparam int PAT_REG_BYTES     = 32;
    localparam int PAT_LIMIT = (MAX_PATTERN_BYTES < PAT_REG_BYTES) ?
                               MAX_PATTERN_BYTES : PAT_REG_BYTES;
    localparam int LEN_W = $clog2(PAT_LIMIT + 1);
    localparam int IDX_W = (PAT_LIMIT > 1) ? $clog2(PAT_LIMIT) : 1;

    // Field widths
    localparam int OFF_W  = 32;
    localparam int ADDR_W = 64;
    localparam int CFG_W  = 64;
    localparam int RIDX_W = 3;

    // Decoupling queue between compare and result stages
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [RIDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_WILDCARD_MASK  = 3'd1,
        REG_PATTERN_WORD_0 = 3'd2,
        REG_PATTERN_WORD_1 = 3'd3,
        REG_PATTERN_WORD_2 = 3'd4,
        REG_PATTERN_WORD_3 = 3'd5,
        REG_REGION_BASE    = 3'd6
    } wbps_reg_t;

    // Pattern aligned to the history: entry k compares against history byte k
    typedef struct packed {
        logic [PAT_LIMIT-1:0]      act;
        logic [PAT_LIMIT-1:0]      wild;
        logic [PAT_LIMIT-1:0][7:0] pat;
        logic [LEN_W-1:0]          len;
    } wbps_win_t;

    // One classified word: a window hit and/or the end of a region
    typedef struct packed {
        logic             hit;
        logic             last;
        logic [OFF_W-1:0] offset;
    } wbps_rec_t;

    typedef struct packed {
        logic      valid;
        wbps_rec_t rec;
    } wbps_push_t;

endpackage

>>> src/wildcard_byte_pattern_search_top.sv
// A byte accepted on s_tdata is shifted into the history registers, its compare result is written
// into the queue, and from there it is loaded into the result register that drives m_tvalid.
// Throughput: one byte per cycle; s_tready drops during a config write cycle and
// when the 4-entry result queue fills under output backpressure.
// Reset (aresetn low, synchronous): clears byte count, queue, match flag and output valid;
// config registers return to length 1, no wildcards, zero pattern and zero base.
module wildcard_byte_pattern_search_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // data_byte
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tlast,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // match_offset[31:0], match_address[95:32]
    output logic [95:0]                    m_tdata,
    // found
    output logic                           m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [wbps_pkg::RIDX_W-1:0]    cfg_wr_index,
    input  logic [wbps_pkg::CFG_W-1:0]     cfg_wr_data
);

    wbps_pkg::wbps_win_t                win;
    logic [wbps_pkg::ADDR_W-1:0]        region_base;
    wbps_pkg::wbps_push_t               push;
    logic [wbps_pkg::FCNT_W-1:0]        q_count;
    logic                               q_valid;
    wbps_pkg::wbps_rec_t                q_rec;
    logic                               pop;

    wbps_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .win          (win),
        .region_base  (region_base)
    );

    wbps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .win       (win),
        .q_count   (q_count),
        .push      (push)
    );

    wbps_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .q_valid (q_valid),
        .q_rec   (q_rec),
        .count   (q_count)
    );

    wbps_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_rec       (q_rec),
        .pop         (pop),
        .region_base (region_base),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

>>> src/wbps_cfg.sv
module wbps_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [wbps_pkg::RIDX_W-1:0]    cfg_wr_index,
    input  logic [wbps_pkg::CFG_W-1:0]     cfg_wr_data,
    output wbps_pkg::wbps_win_t            win,
    output logic [wbps_pkg::ADDR_W-1:0]    region_base
);

    logic [5:0]                              len_raw_reg;
    logic [31:0]                             wild_reg;
    logic [3:0][63:0]                        pw_reg;
    logic [wbps_pkg::ADDR_W-1:0]             base_reg;
    wbps_pkg::wbps_win_t                     win_reg;
    wbps_pkg::wbps_win_t                     win_next;
    logic [5:0]                              eff6;
    logic [wbps_pkg::LEN_W-1:0]              eff_len;
    logic [wbps_pkg::PAT_LIMIT-1:0][7:0]     pbytes;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_raw_reg <= 6'd1;
            wild_reg    <= '0;
            pw_reg      <= '0;
            base_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                wbps_pkg::REG_PATTERN_LENGTH: len_raw_reg <= cfg_wr_data[5:0];
                wbps_pkg::REG_WILDCARD_MASK:  wild_reg    <= cfg_wr_data[31:0];
                wbps_pkg::REG_PATTERN_WORD_0: pw_reg[0]   <= cfg_wr_data;
                wbps_pkg::REG_PATTERN_WORD_1: pw_reg[1]   <= cfg_wr_data;
                wbps_pkg::REG_PATTERN_WORD_2: pw_reg[2]   <= cfg_wr_data;
                wbps_pkg::REG_PATTERN_WORD_3: pw_reg[3]   <= cfg_wr_data;
                wbps_pkg::REG_REGION_BASE:    base_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Clamp length into 1..limit
    always_comb begin
        if (len_raw_reg == 6'd0) begin
            eff6 = 6'd1;
        end else if (len_raw_reg > 6'(wbps_pkg::PAT_LIMIT)) begin
            eff6 = 6'(wbps_pkg::PAT_LIMIT);
        end else begin
            eff6 = len_raw_reg;
        end
    end
    assign eff_len = eff6[wbps_pkg::LEN_W-1:0];

    // Unpack pattern bytes
    for (genvar j = 0; j < wbps_pkg::PAT_LIMIT; j++) begin : g_pbyte
        assign pbytes[j] = pw_reg[j / 8][(j % 8) * 8 +: 8];
    end

    // Reverse the active pattern onto history positions: history k holds pattern len-1-k
    always_comb begin
        logic [wbps_pkg::LEN_W-1:0] idx;
        win_next = '0;
        win_next.len = eff_len;
        for (int k = 0; k < wbps_pkg::PAT_LIMIT; k++) begin
            idx = eff_len - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(k);
            if (wbps_pkg::LEN_W'(k) < eff_len) begin
                win_next.act[k]  = 1'b1;
                win_next.pat[k]  = pbytes[idx[wbps_pkg::IDX_W-1:0]];
                win_next.wild[k] = wild_reg[idx[wbps_pkg::IDX_W-1:0]];
            end
        end
    end

    // Register the aligned pattern every cycle
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign win         = win_reg;
    assign region_base = base_reg;

endmodule

>>> src/wbps_front.sv
module wbps_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tlast,
    input  logic                              cfg_wr_en,
    input  wbps_pkg::wbps_win_t               win,
    input  logic [wbps_pkg::FCNT_W-1:0]       q_count,
    output wbps_pkg::wbps_push_t              push
);

    logic [wbps_pkg::PAT_LIMIT-1:0][7:0] hist_reg;
    logic [wbps_pkg::PAT_LIMIT-1:0][7:0] hist_next;
    logic [wbps_pkg::OFF_W-1:0]          cnt_reg;
    logic [wbps_pkg::OFF_W-1:0]          cnt_inc;
    logic                                counted;
    logic                                s1_valid_reg;
    logic                                s1_last_reg;
    logic                                s1_counted_reg;
    logic [wbps_pkg::OFF_W-1:0]          s1_cnt_reg;
    logic [wbps_pkg::PAT_LIMIT-1:0]      ok;
    logic [wbps_pkg::OFF_W-1:0]          len_ext;
    logic                                hit;
    logic                                accept;

    // Take a word when no config write is under way and the queue has room for everything in flight
    assign s_tready = !cfg_wr_en &&
        ((wbps_pkg::FCNT_W+1)'(q_count) + (wbps_pkg::FCNT_W+1)'(s1_valid_reg)
         < (wbps_pkg::FCNT_W+1)'(wbps_pkg::FIFO_DEPTH));
    assign accept = s_tvalid && s_tready;

    // Shift the new byte into the history
    assign hist_next[0] = s_tdata;
    for (genvar k = 1; k < wbps_pkg::PAT_LIMIT; k++) begin : g_shift
        assign hist_next[k] = hist_reg[k-1];
    end

    // Saturating byte count
    assign counted = (cnt_reg != '1);
    assign cnt_inc = counted ? cnt_reg + wbps_pkg::OFF_W'(1) : cnt_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                cnt_reg <= s_tlast ? '0 : cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_last_reg    <= s_tlast;
            s1_counted_reg <= counted;
            s1_cnt_reg     <= cnt_inc;
        end
    end

    // Masked window compare against the aligned pattern
    always_comb begin
        for (int k = 0; k < wbps_pkg::PAT_LIMIT; k++) begin
            ok[k] = !win.act[k] || win.wild[k] || (hist_reg[k] == win.pat[k]);
        end
    end

    assign len_ext = wbps_pkg::OFF_W'(win.len);
    assign hit     = s1_counted_reg && (s1_cnt_reg >= len_ext) && (&ok);

    // Queue only words that matter to the result side
    assign push.valid      = s1_valid_reg && (hit || s1_last_reg);
    assign push.rec.hit    = hit;
    assign push.rec.last   = s1_last_reg;
    assign push.rec.offset = s1_cnt_reg - len_ext;

endmodule

>>> src/wbps_fifo.sv
module wbps_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wbps_pkg::wbps_push_t          push,
    input  logic                          pop,
    output logic                          q_valid,
    output wbps_pkg::wbps_rec_t           q_rec,
    output logic [wbps_pkg::FCNT_W-1:0]   count
);

    wbps_pkg::wbps_rec_t                 mem_reg [wbps_pkg::FIFO_DEPTH];
    logic [wbps_pkg::FPTR_W-1:0]         wr_ptr_reg;
    logic [wbps_pkg::FPTR_W-1:0]         rd_ptr_reg;
    logic [wbps_pkg::FCNT_W-1:0]         cnt_reg;
    logic                                do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.rec;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + wbps_pkg::FPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + wbps_pkg::FPTR_W'(1);
            end
            case ({push.valid, do_pop})
                2'b10:   cnt_reg <= cnt_reg + wbps_pkg::FCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - wbps_pkg::FCNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_rec   = mem_reg[rd_ptr_reg];
    assign count   = cnt_reg;

    // The front reserves a slot before it takes a word
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> (cnt_reg != wbps_pkg::FCNT_W'(wbps_pkg::FIFO_DEPTH)) || do_pop)
        else $error("queue overflow");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= wbps_pkg::FCNT_W'(wbps_pkg::FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

>>> src/wbps_back.sv
module wbps_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  wbps_pkg::wbps_rec_t           q_rec,
    output logic                          pop,
    input  logic [wbps_pkg::ADDR_W-1:0]   region_base,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,
    output logic                          m_tuser
);

    logic                          reported_reg;
    logic                          reported_next;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic                          found_reg;
    logic [wbps_pkg::OFF_W-1:0]    offset_reg;
    logic [wbps_pkg::ADDR_W-1:0]   addr_reg;
    logic                          out_free;
    logic                          emit;

    // Drain a word whenever the output register can take a result
    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = q_valid && out_free;
    assign emit     = pop && !reported_reg;

    // Track the first hit of the region; drop words after it
    always_comb begin
        reported_next = reported_reg;
        if (pop) begin
            if (q_rec.last) begin
                reported_next = 1'b0;
            end else if (q_rec.hit) begin
                reported_next = 1'b1;
            end
        end
        m_tvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reported_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            reported_reg <= reported_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (emit) begin
            found_reg  <= q_rec.hit;
            offset_reg <= q_rec.hit ? q_rec.offset : '0;
            addr_reg   <= q_rec.hit ?
                          region_base + wbps_pkg::ADDR_W'(q_rec.offset) : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {addr_reg, offset_reg};
    assign m_tuser  = found_reg;

    a_hit_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_rec.hit && !q_rec.last) |=> reported_reg)
        else $error("hit did not close the region");

    a_no_emit_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (reported_reg && !(pop && q_rec.last)) |=> !$rose(m_tvalid_reg))
        else $error("second result in one region");

endmodule
